@@ design/tdcc_pkg.sv @@
// Shared types and constants for the tick deadline calendar counter.
`timescale 1ns / 1ps

package tdcc_pkg;

  // Command codes.
  localparam logic [1:0] CMD_TICK      = 2'd0;
  localparam logic [1:0] CMD_LOAD_UP   = 2'd1;
  localparam logic [1:0] CMD_LOAD_NEAR = 2'd2;

  // The sub-second part of the deadline is kept as a count of 10 ms ticks.
  localparam int TICK_W = 7;
  localparam logic [TICK_W-1:0] TICKS_PER_SEC = 7'd100;

  // Rounding biases added to the loaded microseconds.
  localparam logic [20:0] ROUND_UP_ADD   = 21'd9999;
  localparam logic [20:0] ROUND_NEAR_ADD = 21'd5000;

  // Division by 10000: drop four bits, then multiply by ceil(2^26 / 625).
  // Exact for every quotient input below 131328.
  localparam logic [33:0] RECIP_MUL   = 34'd107375;
  localparam int          RECIP_SHIFT = 26;

  localparam logic [5:0] SEC_PER_MIN   = 6'd60;
  localparam logic [5:0] MIN_PER_HOUR  = 6'd60;
  localparam logic [4:0] HOURS_PER_DAY = 5'd24;
  localparam logic [8:0] DAYS_LEAP     = 9'd366;
  localparam logic [8:0] DAYS_COMMON   = 9'd365;

  localparam logic [10:0] MIN_PER_HOUR_W = 11'd60;
  localparam logic [16:0] SEC_PER_MIN_W  = 17'd60;
  localparam logic [26:0] MS_PER_SEC     = 27'd1000;
  localparam logic [26:0] MS_PER_TICK    = 27'd10;
  localparam logic [19:0] US_PER_TICK    = 20'd10000;

  typedef struct packed {
    logic [15:0] year;
    logic [8:0]  yday;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } cal_t;

endpackage

@@ design/tdcc_if.sv @@
// Valid/ready channel interfaces for commands and deadline results.
`timescale 1ns / 1ps

interface tdcc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [15:0] in_year;
  logic [8:0]  in_yday;
  logic [4:0]  in_hour;
  logic [5:0]  in_minute;
  logic [5:0]  in_second;
  logic [19:0] in_usec;

  modport source (
    output valid, cmd, in_year, in_yday, in_hour, in_minute, in_second, in_usec,
    input  ready
  );
  modport sink (
    input  valid, cmd, in_year, in_yday, in_hour, in_minute, in_second, in_usec,
    output ready
  );
endinterface

interface tdcc_res_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_year;
  logic [8:0]  out_yday;
  logic [4:0]  out_hour;
  logic [5:0]  out_minute;
  logic [5:0]  out_second;
  logic [19:0] out_usec;
  logic [26:0] ms_of_day;

  modport source (
    output valid, out_year, out_yday, out_hour, out_minute, out_second, out_usec,
           ms_of_day,
    input  ready
  );
  modport sink (
    input  valid, out_year, out_yday, out_hour, out_minute, out_second, out_usec,
           ms_of_day,
    output ready
  );
endinterface

@@ design/tdcc_next.sv @@
// Next deadline: tick advance or rounded load, followed by the calendar carry chain.
`timescale 1ns / 1ps

module tdcc_next import tdcc_pkg::*; (
  input  logic [1:0]        cmd,
  input  cal_t              load_time,
  input  logic [19:0]       load_usec,
  input  cal_t              cur,
  input  logic [TICK_W-1:0] cur_ticks,
  output cal_t              nxt,
  output logic [TICK_W-1:0] nxt_ticks
);

  logic [20:0]       biased;
  logic [16:0]       scaled;
  logic [33:0]       prod;
  logic [TICK_W-1:0] q;
  logic [TICK_W-1:0] raw;
  logic              carry;
  cal_t              base;
  logic [5:0]        sec1;
  logic [5:0]        min1;
  logic [4:0]        hour1;
  logic [8:0]        yday1;
  logic [8:0]        days;
  logic [15:0]       year1;

  // Rounded tick count of a loaded time; may reach 105 and then carries.
  always_comb begin
    biased = {1'b0, load_usec} + ((cmd == CMD_LOAD_UP) ? ROUND_UP_ADD : ROUND_NEAR_ADD);
    scaled = biased[20:4];
    prod   = {17'd0, scaled} * RECIP_MUL;
    q      = prod[RECIP_SHIFT+TICK_W-1:RECIP_SHIFT];
  end

  always_comb begin
    unique case (cmd)
      CMD_TICK: begin
        base = cur;
        raw  = cur_ticks + 7'd1;
      end
      CMD_LOAD_UP, CMD_LOAD_NEAR: begin
        base = load_time;
        raw  = q;
      end
      default: begin
        base = cur;
        raw  = cur_ticks;
      end
    endcase

    carry     = (raw >= TICKS_PER_SEC);
    nxt_ticks = carry ? raw - TICKS_PER_SEC : raw;

    sec1  = base.second + 6'd1;
    min1  = base.minute + 6'd1;
    hour1 = base.hour + 5'd1;
    yday1 = base.yday + 9'd1;
    year1 = base.year + 16'd1;
    days  = (base.year[1:0] == 2'b00) ? DAYS_LEAP : DAYS_COMMON;

    // Each unit rolls over on "at or above its limit", so out-of-range loaded
    // fields return to zero on the first carry that reaches them.
    nxt = base;
    if (carry) begin
      if (sec1 < SEC_PER_MIN) begin
        nxt.second = sec1;
      end else begin
        nxt.second = 6'd0;
        if (min1 < MIN_PER_HOUR) begin
          nxt.minute = min1;
        end else begin
          nxt.minute = 6'd0;
          if (hour1 < HOURS_PER_DAY) begin
            nxt.hour = hour1;
          end else begin
            nxt.hour = 5'd0;
            if (yday1 < days) begin
              nxt.yday = yday1;
            end else begin
              nxt.yday = 9'd0;
              nxt.year = year1;
            end
          end
        end
      end
    end
  end

endmodule

@@ design/tick_deadline_calendar_counter.sv @@
// Top level of the tick deadline calendar counter.
`timescale 1ns / 1ps

// The block keeps the next 10 ms deadline as year, day of year, hour, minute,
// second and 10 ms ticks, and answers every command beat with one result
// beat: the deadline after the command and its milliseconds since midnight.
// Command 0 advances by one tick, command 1 loads a time rounded up to the
// next tick, command 2 loads a time rounded to the nearest tick; code 3 only
// reports the deadline. A command is taken in every cycle unless the command
// side stalls. Its result passes first through the deadline register, which
// updates on the accepting edge, then the seconds of day are registered, and
// the milliseconds and microseconds land in the output register after that.
// The command side stalls only when all three stages hold results that
// the result side has not yet taken.

module tick_deadline_calendar_counter import tdcc_pkg::*; (
  input logic          clk,
  input logic          rst,
  tdcc_req_if.sink     req,
  tdcc_res_if.source   res
);

  cal_t              dl;
  logic [TICK_W-1:0] dl_ticks;
  logic              va;
  cal_t              b_time;
  logic [TICK_W-1:0] b_ticks;
  logic [16:0]       b_sec;
  logic              vb;

  cal_t              load_time;
  cal_t              nxt;
  logic [TICK_W-1:0] nxt_ticks;
  logic [10:0]       min_of_day;
  logic [16:0]       sec_of_day;
  logic              adv_c;
  logic              move_b;
  logic              move_a;
  logic              accept;

  assign load_time = '{year: req.in_year, yday: req.in_yday, hour: req.in_hour,
                       minute: req.in_minute, second: req.in_second};

  tdcc_next u_next (
    .cmd       (req.cmd),
    .load_time (load_time),
    .load_usec (req.in_usec),
    .cur       (dl),
    .cur_ticks (dl_ticks),
    .nxt       (nxt),
    .nxt_ticks (nxt_ticks)
  );

  assign adv_c     = !res.valid || res.ready;
  assign move_b    = vb && adv_c;
  assign move_a    = va && (!vb || adv_c);
  assign req.ready = !va || move_a;
  assign accept    = req.valid && req.ready;

  assign min_of_day = {6'd0, dl.hour} * MIN_PER_HOUR_W + {5'd0, dl.minute};
  assign sec_of_day = {6'd0, min_of_day} * SEC_PER_MIN_W + {11'd0, dl.second};

  always_ff @(posedge clk) begin
    if (rst) begin
      dl        <= '0;
      dl_ticks  <= '0;
      va        <= 1'b0;
      vb        <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      if (accept) begin
        dl       <= nxt;
        dl_ticks <= nxt_ticks;
        va       <= 1'b1;
      end else if (move_a) begin
        va <= 1'b0;
      end

      if (move_a) begin
        vb <= 1'b1;
      end else if (move_b) begin
        vb <= 1'b0;
      end

      if (move_b) begin
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  // The deadline register is read here on the same edge that may overwrite it.
  always_ff @(posedge clk) begin
    if (move_a) begin
      b_time  <= dl;
      b_ticks <= dl_ticks;
      b_sec   <= sec_of_day;
    end
    if (move_b) begin
      res.out_year   <= b_time.year;
      res.out_yday   <= b_time.yday;
      res.out_hour   <= b_time.hour;
      res.out_minute <= b_time.minute;
      res.out_second <= b_time.second;
      res.out_usec   <= {13'd0, b_ticks} * US_PER_TICK;
      res.ms_of_day  <= {10'd0, b_sec} * MS_PER_SEC + {20'd0, b_ticks} * MS_PER_TICK;
    end
  end

endmodule

@@ design/tdcc_checker.sv @@
// Port-level assertions for the tick deadline calendar counter, bound to its top level.
`timescale 1ns / 1ps

module tdcc_checker (
  input logic        clk,
  input logic        rst,
  tdcc_req_if.sink   req,
  tdcc_res_if.source res
);

  // A result beat that is held back keeps its milliseconds, microseconds and year.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.ready |=> res.valid && $stable(res.ms_of_day)
      && $stable(res.out_usec) && $stable(res.out_year))
    else $error("stalled result beat changed");

  // Reset empties the pipeline; no result beat is present afterwards.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res.valid)
    else $error("result beat present after reset");

  // Commands are refused only when the result side is full and stalled.
  a_ready_backpressure: assert property (@(posedge clk) disable iff (rst)
    !req.ready |-> res.valid && !res.ready)
    else $error("command side stalled without result backpressure");

  // The deadline always sits on a 10 ms boundary, in both result forms.
  a_tick_grid: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (res.out_usec <= 20'd990000) && (res.out_usec % 10000 == 0)
      && (res.ms_of_day % 10 == 0))
    else $error("deadline off the tick grid");

endmodule

bind tick_deadline_calendar_counter tdcc_checker u_tdcc_checker (
  .clk (clk),
  .rst (rst),
  .req (req),
  .res (res)
);
